/* rtl/core/b64se_pkg.sv */
// Base64 stream encoder package: group descriptor type, queue depth,
// pad character and the sextet-to-ASCII alphabet function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64se_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam logic [2:0] NcharFull = 3'd4;
  localparam logic [2:0] NcharOne  = 3'd2;
  localparam logic [2:0] NcharTwo  = 3'd3;

  // One 24-bit group handed from the front to the back.
  typedef struct packed {
    logic [23:0] group;
    logic [2:0]  nchar;  // characters that carry data, rest are pad
    logic        last;
  } b64se_grp_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         c = 8'h2B;
      default:       c = 8'h2F;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/b64se_if.sv */
// Valid/ready channel interfaces for the Base64 stream encoder:
// raw byte requests in, ASCII character requests out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface b64se_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64se_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/b64se_front.sv */
// Front end: collects bytes into 24-bit groups and pushes one descriptor
// per finished or closing group. Depends on b64se_pkg, b64se_if.
`timescale 1ns / 1ps
`default_nettype none

module b64se_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  b64se_byte_if.sink                 byte_i,
  output      logic                  push_valid_o,
  input  wire logic                  push_ready_i,
  output      b64se_pkg::b64se_grp_t push_data_o
);

  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] pend_q, pend_d;
  logic        acc;
  logic        emit;

  assign byte_i.ready = push_ready_i;
  assign acc          = byte_i.valid && byte_i.ready;
  assign emit         = cnt_q[1] || byte_i.end_of_message;
  assign push_valid_o = byte_i.valid && emit;

  always_comb begin
    push_data_o = '0;
    if (cnt_q[1]) begin
      push_data_o.group = {pend_q, byte_i.data_byte};
      push_data_o.nchar = b64se_pkg::NcharFull;
      push_data_o.last  = byte_i.end_of_message;
    end else if (cnt_q == 2'd0) begin
      push_data_o.group = {byte_i.data_byte, 16'h0000};
      push_data_o.nchar = b64se_pkg::NcharOne;
      push_data_o.last  = 1'b1;
    end else begin
      push_data_o.group = {pend_q[7:0], byte_i.data_byte, 8'h00};
      push_data_o.nchar = b64se_pkg::NcharTwo;
      push_data_o.last  = 1'b1;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    pend_d = pend_q;
    if (acc) begin
      if (emit) begin
        cnt_d  = 2'd0;
        pend_d = '0;
      end else begin
        cnt_d  = cnt_q + 2'd1;
        pend_d = {pend_q[7:0], byte_i.data_byte};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      pend_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("pending count reached three");

  a_eom_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && byte_i.end_of_message |-> push_valid_o && push_data_o.last)
    else $error("end of message byte not pushed as last group");

endmodule

`default_nettype wire

/* rtl/core/b64se_fifo.sv */
// Short group queue between front and back ends.
// Depends on b64se_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64se_fifo #(
  parameter int unsigned Depth = b64se_pkg::QueueDepth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_valid_i,
  output      logic                  push_ready_o,
  input  wire b64se_pkg::b64se_grp_t push_data_i,
  output      logic                  pop_valid_o,
  input  wire logic                  pop_ready_i,
  output      b64se_pkg::b64se_grp_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64se_pkg::b64se_grp_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    if (pop)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    if (push && !pop)      cnt_d = cnt_q + CntW'(1);
    else if (pop && !push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("group queue overflow");

endmodule

`default_nettype wire

/* rtl/core/b64se_back.sv */
// Back end: serializes one group into four characters through the
// output register. Depends on b64se_pkg, b64se_if.
`timescale 1ns / 1ps
`default_nettype none

module b64se_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pop_valid_i,
  output      logic                  pop_ready_o,
  input  wire b64se_pkg::b64se_grp_t pop_data_i,
  b64se_char_if.source               char_o
);

  logic                  busy_q, busy_d;
  logic [1:0]            k_q, k_d;
  b64se_pkg::b64se_grp_t cur_q;
  logic                  ov_q, ov_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic                  load, fin, pop;
  logic [5:0]            sextet;

  assign load        = busy_q && (!ov_q || char_o.ready);
  assign fin         = load && (k_q == 2'd3);
  assign pop_ready_o = !busy_q || fin;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    case (k_q)
      2'd0:    sextet = cur_q.group[23:18];
      2'd1:    sextet = cur_q.group[17:12];
      2'd2:    sextet = cur_q.group[11:6];
      default: sextet = cur_q.group[5:0];
    endcase
    char_d = ({1'b0, k_q} < cur_q.nchar) ? b64se_pkg::b64_char(sextet)
                                          : b64se_pkg::PadChar;
    last_d = cur_q.last && (k_q == 2'd3);
  end

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (fin) busy_d = 1'b0;
    if (pop) begin
      busy_d = 1'b1;
      k_d    = 2'd0;
    end else if (load) begin
      k_d = k_q + 2'd1;
    end
    ov_d = ov_q;
    if (load)              ov_d = 1'b1;
    else if (char_o.ready) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= 2'd0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) cur_q <= pop_data_i;
    if (load) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  assign char_o.valid    = ov_q;
  assign char_o.out_char = char_q;
  assign char_o.out_last = last_q;

  a_no_early_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (k_q < 2'd2) |=> char_q != b64se_pkg::PadChar)
    else $error("pad emitted in a data position");

endmodule

`default_nettype wire

/* rtl/core/base64_stream_encoder.sv */
// Top level of the Base64 stream encoder: front end, group queue, back end.
// Depends on b64se_pkg, b64se_if, b64se_front, b64se_fifo, b64se_back.
//
//   channel  dir  payload                       handshake
//   byte_i   in   data_byte[7:0], end_of_message valid/ready
//   char_o   out  out_char[7:0], out_last        valid/ready
//
// Characters leave at one per cycle from the back-end serializer while the
// output is ready, so a full group of three bytes yields four characters.
// A short final group always yields four characters, padding included.
// A closing group goes through the queue, group register and output register.
// Reset clears the pending bytes, the queue and the serializer at once.
// Input stalls only when the queue is full; output stalls back up into it.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64se_pkg::QueueDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  b64se_byte_if.sink   byte_i,
  b64se_char_if.source char_o
);

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  b64se_pkg::b64se_grp_t push_data, pop_data;

  b64se_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  b64se_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  b64se_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .char_o      (char_o)
  );

endmodule

`default_nettype wire
